### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/dret_pkg.sv
// ----------------------------------------------------------------------------
// dret_pkg
// Types and constants shared by the difficulty retarget modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dret_pkg;

    localparam int TARGET_WIDTH_DEF = 256;
    localparam int FIFO_DEPTH       = 2;
    localparam int ACT_W            = 34;

    localparam logic [31:0] TIMESPAN_RST = 32'd1209600;
    localparam logic [31:0] LIMIT_RST    = 32'h1d00ffff;

    typedef enum logic [2:0] {
        CFG_NO_RETARGET   = 3'd0,
        CFG_FORK_HEIGHT   = 3'd1,
        CFG_LEGACY_SPAN   = 3'd2,
        CFG_FORK_SPAN     = 3'd3,
        CFG_LEGACY_LIMIT  = 3'd4,
        CFG_FORK_LIMIT    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        no_retarget;
        logic [30:0] fork_height;
        logic [31:0] legacy_timespan;
        logic [31:0] fork_timespan;
        logic [31:0] legacy_limit_bits;
        logic [31:0] fork_limit_bits;
    } t_cfg;

    typedef struct packed {
        logic             bypass;
        logic [31:0]      bits;
        logic [ACT_W-1:0] act;
        logic [31:0]      span;
        logic [31:0]      limit_bits;
    } t_job;

endpackage

`default_nettype wire

### rtl/dret_front.sv
// ----------------------------------------------------------------------------
// dret_front
// Classify an item: pick the era, clamp the elapsed time, build a job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dret_front (
    input  wire dret_pkg::t_cfg i_cfg,
    input  wire [31:0]          i_last_bits,
    input  wire [30:0]          i_last_height,
    input  wire [31:0]          i_last_time,
    input  wire [31:0]          i_first_time,
    output dret_pkg::t_job      o_job
);
    import dret_pkg::*;

    logic               forked;
    logic [31:0]        span;
    logic [ACT_W-1:0]   lo;
    logic [ACT_W-1:0]   hi;
    logic signed [34:0] diff;

    always_comb begin
        forked = i_last_height > i_cfg.fork_height;
        span   = forked ? i_cfg.fork_timespan : i_cfg.legacy_timespan;
        lo     = forked ? ACT_W'(span >> 1) : ACT_W'(span >> 2);
        hi     = forked ? {1'b0, span, 1'b0} : {span, 2'b00};
        diff   = $signed({3'b000, i_last_time}) - $signed({3'b000, i_first_time});

        o_job.bypass     = i_cfg.no_retarget;
        o_job.bits       = i_last_bits;
        o_job.span       = span;
        o_job.limit_bits = forked ? i_cfg.fork_limit_bits : i_cfg.legacy_limit_bits;
        if (diff < $signed({1'b0, lo})) begin
            o_job.act = lo;
        end else if (diff > $signed({1'b0, hi})) begin
            o_job.act = hi;
        end else begin
            o_job.act = diff[ACT_W-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/dret_fifo.sv
// ----------------------------------------------------------------------------
// dret_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dret_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire dret_pkg::t_job i_job,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output dret_pkg::t_job      o_job
);
    import dret_pkg::*;
    `include "assert_macros.svh"

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_job          r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    `ASSERT_CLK(a_count_bound, r_count <= CW'(FIFO_DEPTH), "queue count out of range")
    `ASSERT_CLK(a_no_overflow, !(i_push && o_full && !i_pop), "push into full queue")
    `ASSERT_CLK(a_no_underflow, i_pop |-> !o_empty, "pop from empty queue")

endmodule

`default_nettype wire

### rtl/dret_back.sv
// ----------------------------------------------------------------------------
// dret_back
// Run a job: decode, shift-add multiply, restoring divide, clamp, encode; a bypass job passes its bits through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dret_back #(
    parameter int TARGET_WIDTH = dret_pkg::TARGET_WIDTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_empty,
    input  wire dret_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [31:0]         o_next_bits
);
    import dret_pkg::*;
    `include "assert_macros.svh"

    localparam int W      = TARGET_WIDTH;
    localparam int CW     = $clog2(W);
    localparam int NBYTES = (W + 7) / 8;
    localparam int XW     = NBYTES * 8;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_DIV   = 6'b000100,
        S_CLAMP = 6'b001000,
        S_PACK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    function automatic logic [W-1:0] unpack(input logic [31:0] bits);
        logic [7:0]  e;
        logic [23:0] m;
        logic [10:0] sh;
        e  = bits[31:24];
        m  = {1'b0, bits[22:0]};
        sh = {e - 8'd3, 3'b000};
        case (e)
            8'd0:    unpack = '0;
            8'd1:    unpack = W'(m >> 16);
            8'd2:    unpack = W'(m >> 8);
            8'd3:    unpack = W'(m);
            default: unpack = W'(m) << sh;
        endcase
    endfunction

    t_state           r_state;
    logic [W-1:0]     r_tgt;
    logic [W-1:0]     r_lim;
    logic [W-1:0]     r_acc;
    logic [ACT_W-1:0] r_act;
    logic [31:0]      r_span;
    logic [31:0]      r_rem;
    logic [CW-1:0]    r_cnt;
    logic [XW-1:0]    r_x;
    logic [7:0]       r_size;
    logic [31:0]      r_res;

    logic [32:0]      rem2;
    logic             ge;
    logic [23:0]      mant;
    logic             out_free;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign rem2     = {r_rem, r_acc[W-1]};
    assign ge       = rem2 >= {1'b0, r_span};
    assign mant     = r_x[XW-1 -: 24];
    assign out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            // raise on a finished job, hold while stalled, drop once taken
            o_out_valid <= (r_state == S_DONE && out_free) || (o_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= i_job.bypass ? S_DONE : S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_cnt == CW'(ACT_W - 1)) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CW'(W - 1)) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: r_state <= S_PACK;
                S_PACK: begin
                    if (r_size == '0 || mant[23:16] != '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_tgt  <= unpack(i_job.bits);
                r_lim  <= unpack(i_job.limit_bits);
                r_act  <= i_job.act;
                r_span <= i_job.span;
                r_acc  <= '0;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_res  <= i_job.bits;
            end
            S_MUL: begin
                // MSB-first shift-add, product wraps at the target width
                r_acc <= (r_acc << 1) + (r_act[ACT_W-1] ? r_tgt : '0);
                r_act <= r_act << 1;
                r_cnt <= (r_cnt == CW'(ACT_W - 1)) ? '0 : r_cnt + 1'b1;
            end
            S_DIV: begin
                // restoring step; a zero divisor yields all-ones quotient
                r_rem <= ge ? 32'(rem2 - {1'b0, r_span}) : rem2[31:0];
                r_acc <= {r_acc[W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_CLAMP: begin
                r_x    <= XW'((r_acc > r_lim) ? r_lim : r_acc);
                r_size <= 8'(NBYTES);
            end
            S_PACK: begin
                if (r_size != '0 && mant[23:16] == '0) begin
                    r_x    <= r_x << 8;
                    r_size <= r_size - 1'b1;
                end else if (r_size == '0) begin
                    r_res <= '0;
                end else if (mant[23]) begin
                    r_res <= {r_size + 8'd1, 8'h00, mant[23:8]};
                end else begin
                    r_res <= {r_size, mant};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_next_bits <= r_res;
        end
    end

    `ASSERT_CLK(a_mul_count, (r_state == S_MUL) |-> (r_cnt < CW'(ACT_W)),
                "multiply step count overrun")
    `ASSERT_CLK(a_rem_below, (r_state == S_DIV && r_span != '0) |-> (r_rem < r_span),
                "partial remainder not below divisor")
    `ASSERT_CLK(a_out_from_done, $rose(o_out_valid) |-> $past(r_state == S_DONE),
                "result shown without finished job")

endmodule

`default_nettype wire

### rtl/difficulty_retarget_top.sv
// ----------------------------------------------------------------------------
// difficulty_retarget_top
// Next compact proof-of-work target from the last window of blocks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | sink      | i_in_valid / o_in_stall  | last_bits, height, times
//  out     | source    | o_out_valid / i_out_stall| next_bits
//  cfg     | sink      | i_cfg_valid / o_cfg_ready| cfg_index, cfg_data
//
//  Steps: a bypass item goes from idle straight to done; a retarget runs a load,
//  a bit-serial multiply, a bit-serial divide, a clamp, a byte-wise encode and a
//  done step; at width 256 the bit-serial divider in the back is the longest step.
//  Reset: synchronous, active low; config returns to its defaults, queue empties.
//  Stalls: the queue holds two jobs, so input is taken while the back works and
//  while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module difficulty_retarget_top #(
    parameter int TARGET_WIDTH = dret_pkg::TARGET_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input items
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [31:0] i_last_bits,
    input  wire  [30:0] i_last_height,
    input  wire  [31:0] i_last_time,
    input  wire  [31:0] i_first_time,
    // result items
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [31:0] o_next_bits,
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    import dret_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job queue_job;
    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;

    // Registers are always writable; writes must happen only while idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.no_retarget       <= 1'b0;
            r_cfg.fork_height       <= '0;
            r_cfg.legacy_timespan   <= TIMESPAN_RST;
            r_cfg.fork_timespan     <= TIMESPAN_RST;
            r_cfg.legacy_limit_bits <= LIMIT_RST;
            r_cfg.fork_limit_bits   <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NO_RETARGET:  r_cfg.no_retarget       <= i_cfg_data[0];
                CFG_FORK_HEIGHT:  r_cfg.fork_height       <= i_cfg_data[30:0];
                CFG_LEGACY_SPAN:  r_cfg.legacy_timespan   <= i_cfg_data;
                CFG_FORK_SPAN:    r_cfg.fork_timespan     <= i_cfg_data;
                CFG_LEGACY_LIMIT: r_cfg.legacy_limit_bits <= i_cfg_data;
                CFG_FORK_LIMIT:   r_cfg.fork_limit_bits   <= i_cfg_data;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // Stall the input only when the job queue is full.
    assign o_in_stall = queue_full;
    assign push       = i_in_valid && !queue_full;

    dret_front u_front (
        .i_cfg         (r_cfg),
        .i_last_bits   (i_last_bits),
        .i_last_height (i_last_height),
        .i_last_time   (i_last_time),
        .i_first_time  (i_first_time),
        .o_job         (front_job)
    );

    dret_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_job   (queue_job)
    );

    dret_back #(
        .TARGET_WIDTH (TARGET_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_next_bits (o_next_bits)
    );

endmodule

`default_nettype wire
